// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the pipe pool, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequence that must hold after the antecedent (non-overlapping implication)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/ppbf_pkg.sv
// ---------------------------------------------------------------------------
// ppbf_pkg
// shared types, sizes and codes of the pipe pool byte fifo
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppbf_pkg;

  // pool sizing
  localparam int NUM_PIPES = 16;
  localparam int BUF_DEPTH = 256;
  localparam int REF_MAX   = 255;

  // field widths of a beat
  localparam int OP_W    = 3;
  localparam int ID_W    = 4;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int TALLY_W = 9;

  // derived widths
  localparam int PIPE_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int FILL_W  = PTR_W + 1;
  localparam int REF_W   = $clog2(REF_MAX + 1);
  localparam int ADDR_W  = PIPE_W + PTR_W;
  localparam int STORE_D = NUM_PIPES * BUF_DEPTH;
  localparam int TALLY_MAX = (1 << TALLY_W) - 1;

  // operation codes on the input
  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_DUP_W   = 3'd3,
    OP_DUP_R   = 3'd4,
    OP_CLOSE_W = 3'd5,
    OP_CLOSE_R = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_BADF   = 3'd1,
    ST_PIPE   = 3'd2,
    ST_AGAIN  = 3'd3,
    ST_EOF    = 3'd4,
    ST_NOPIPE = 3'd5
  } status_t;

  // command class decided by the front end
  typedef enum logic [2:0] {
    K_NONE,
    K_CREATE,
    K_WRITE,
    K_READ,
    K_DUP_W,
    K_DUP_R,
    K_CLOSE_W,
    K_CLOSE_R
  } cmd_kind_t;

  // one classified command in the queue
  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   pipe_id;
    logic [BYTE_W-1:0] data;
    logic              fin;
  } cmd_t;

  // back end sequencer states
  typedef enum logic {
    BK_RUN,
    BK_READ
  } back_state_t;

endpackage

// File: rtl/core/pipe_pool_byte_fifo.sv
// ---------------------------------------------------------------------------
// pipe_pool_byte_fifo
// pool of byte pipes with reference counts, one result beat per command beat
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   input     in_valid / in_stall    op, pipe_id, wr_byte, final_byte
//   output    out_valid / out_stall  status, new_pipe, rd_byte, moved_count
//
// a command beat is held in a front queue slot, then the back end executes it
// into the output register; a byte moving read passes the registered store read
// one beat per cycle while out_stall is low; a successful read stalls the back end
// the two entry queue keeps accepting while a result waits on out_stall, until full
// synchronous reset clears the pipe table and tally; no store clearing pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipe_pool_byte_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppbf_pkg::OP_W-1:0]    op,
  input  logic [ppbf_pkg::ID_W-1:0]    pipe_id,
  input  logic [ppbf_pkg::BYTE_W-1:0]  wr_byte,
  input  logic                         final_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppbf_pkg::STAT_W-1:0]  status,
  output logic [ppbf_pkg::ID_W-1:0]    new_pipe,
  output logic [ppbf_pkg::BYTE_W-1:0]  rd_byte,
  output logic [ppbf_pkg::TALLY_W-1:0] moved_count
);
  import ppbf_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // accept and classify
  ppbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pipe_id    (pipe_id),
    .wr_byte    (wr_byte),
    .final_byte (final_byte),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop)
  );

  // execute
  ppbf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .new_pipe    (new_pipe),
    .rd_byte     (rd_byte),
    .moved_count (moved_count)
  );

endmodule

// File: rtl/core/ppbf_ram.sv
// ---------------------------------------------------------------------------
// ppbf_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ppbf_front.sv
// ---------------------------------------------------------------------------
// ppbf_front
// accepts input beats, classifies the op and holds them in a two entry queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppbf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ppbf_pkg::OP_W-1:0]   op,
  input  logic [ppbf_pkg::ID_W-1:0]   pipe_id,
  input  logic [ppbf_pkg::BYTE_W-1:0] wr_byte,
  input  logic                      final_byte,
  output logic                      q_valid,
  output ppbf_pkg::cmd_t            q_cmd,
  input  logic                      pop
);
  import ppbf_pkg::*;

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cls;

  // classify the incoming op
  always_comb begin
    cls.pipe_id = pipe_id;
    cls.data    = wr_byte;
    cls.fin     = final_byte;
    case (op)
      OP_CREATE:  cls.kind = K_CREATE;
      OP_WRITE:   cls.kind = K_WRITE;
      OP_READ:    cls.kind = K_READ;
      OP_DUP_W:   cls.kind = K_DUP_W;
      OP_DUP_R:   cls.kind = K_DUP_R;
      OP_CLOSE_W: cls.kind = K_CLOSE_W;
      OP_CLOSE_R: cls.kind = K_CLOSE_R;
      default:    cls.kind = K_NONE;
    endcase
  end

  // queue handshakes
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rptr];

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cls;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= 2'd2)
  `ASSERT_ALWAYS(a_no_pop_empty, clk, rst, !pop || (count != 2'd0))
  `ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 2'd1)

endmodule

// File: rtl/core/ppbf_back.sv
// ---------------------------------------------------------------------------
// ppbf_back
// executes queued commands against the pipe table and the byte store
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppbf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ppbf_pkg::cmd_t               q_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppbf_pkg::STAT_W-1:0]  status,
  output logic [ppbf_pkg::ID_W-1:0]    new_pipe,
  output logic [ppbf_pkg::BYTE_W-1:0]  rd_byte,
  output logic [ppbf_pkg::TALLY_W-1:0] moved_count
);
  import ppbf_pkg::*;

  localparam logic [ID_W:0]   ID_LIMIT = (ID_W + 1)'(NUM_PIPES);
  localparam logic [FILL_W-1:0] FULL   = FILL_W'(BUF_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_TOP = PTR_W'(BUF_DEPTH - 1);
  localparam logic [REF_W-1:0]  REF_TOP = REF_W'(REF_MAX);
  localparam logic [TALLY_W-1:0] TALLY_TOP = TALLY_W'(TALLY_MAX);

  // pipe table
  logic              in_use [NUM_PIPES];
  logic [PTR_W-1:0]  wr_ptr [NUM_PIPES];
  logic [PTR_W-1:0]  rd_ptr [NUM_PIPES];
  logic [FILL_W-1:0] fill   [NUM_PIPES];
  logic [REF_W-1:0]  wrefs  [NUM_PIPES];
  logic [REF_W-1:0]  rrefs  [NUM_PIPES];
  logic [TALLY_W-1:0] tally;

  back_state_t state, state_next;

  // result registers
  status_t            res_status;
  logic [TALLY_W-1:0] pend_moved;

  // decode of the head command
  logic [PIPE_W-1:0]  idx;
  logic               id_ok;
  logic               idx_idle;
  logic               free_found;
  logic [PIPE_W-1:0]  free_idx;
  logic               is_xfer;
  logic               xfer_ok;
  logic               wr_ok;
  logic               rd_ok;
  status_t            st;
  logic [ID_W-1:0]    grant;
  logic [TALLY_W-1:0] tally_inc;
  logic [TALLY_W-1:0] moved;
  logic [TALLY_W-1:0] tally_next;
  logic [REF_W-1:0]   w_dec;
  logic [REF_W-1:0]   r_dec;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign idx   = q_cmd.pipe_id[PIPE_W-1:0];
  assign id_ok = ({1'b0, q_cmd.pipe_id} < ID_LIMIT) && in_use[idx];
  assign waddr = {idx, wr_ptr[idx]};
  assign raddr = {idx, rd_ptr[idx]};
  assign w_dec = (wrefs[idx] == '0) ? '0 : wrefs[idx] - REF_W'(1);
  assign r_dec = (rrefs[idx] == '0) ? '0 : rrefs[idx] - REF_W'(1);

  // addressed pipe holds no bytes and no references
  assign idx_idle = (fill[idx] == '0) && (wrefs[idx] == '0) && (rrefs[idx] == '0);

  // lowest free pipe
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = NUM_PIPES - 1; k >= 0; k--) begin
      if (!in_use[k]) begin
        free_found = 1'b1;
        free_idx   = PIPE_W'(k);
      end
    end
  end

  // status, transfer checks and tally
  always_comb begin
    st      = ST_OK;
    grant   = '0;
    wr_ok   = 1'b0;
    rd_ok   = 1'b0;
    is_xfer = (q_cmd.kind == K_WRITE) || (q_cmd.kind == K_READ);
    case (q_cmd.kind)
      K_CREATE: begin
        if (free_found) begin
          grant = ID_W'(free_idx);
        end else begin
          st = ST_NOPIPE;
        end
      end
      K_WRITE: begin
        if (!id_ok) begin
          st = ST_BADF;
        end else if (rrefs[idx] == '0) begin
          st = ST_PIPE;
        end else if (fill[idx] >= FULL) begin
          st = ST_AGAIN;
        end else begin
          wr_ok = 1'b1;
        end
      end
      K_READ: begin
        if (!id_ok) begin
          st = ST_BADF;
        end else if (fill[idx] == '0) begin
          st = (wrefs[idx] == '0) ? ST_EOF : ST_AGAIN;
        end else begin
          rd_ok = 1'b1;
        end
      end
      K_DUP_W, K_DUP_R, K_CLOSE_W, K_CLOSE_R: begin
        if (!id_ok) begin
          st = ST_BADF;
        end
      end
      default: st = ST_OK;
    endcase
    xfer_ok   = wr_ok || rd_ok;
    tally_inc = (tally == TALLY_TOP) ? tally : tally + TALLY_W'(1);
    if (!is_xfer) begin
      moved      = '0;
      tally_next = tally;
    end else if (xfer_ok) begin
      moved      = tally_inc;
      tally_next = q_cmd.fin ? '0 : tally_inc;
    end else begin
      moved      = tally;
      tally_next = '0;
    end
  end

  // sequencer: one command per cycle unless the output is stalled, a successful read waits for the store
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      BK_RUN: begin
        if (q_valid && (!out_valid || !out_stall)) begin
          pop = 1'b1;
          if (rd_ok) begin
            state_next = BK_READ;
          end
        end
      end
      BK_READ: state_next = BK_RUN;
      default: state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // pipe table and tally updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PIPES; k++) begin
        in_use[k] <= 1'b0;
        wr_ptr[k] <= '0;
        rd_ptr[k] <= '0;
        fill[k]   <= '0;
        wrefs[k]  <= '0;
        rrefs[k]  <= '0;
      end
      tally <= '0;
    end else if (pop) begin
      tally <= tally_next;
      case (q_cmd.kind)
        K_CREATE: begin
          if (free_found) begin
            in_use[free_idx] <= 1'b1;
            wr_ptr[free_idx] <= '0;
            rd_ptr[free_idx] <= '0;
            fill[free_idx]   <= '0;
            wrefs[free_idx]  <= REF_W'(1);
            rrefs[free_idx]  <= REF_W'(1);
          end
        end
        K_WRITE: begin
          if (wr_ok) begin
            wr_ptr[idx] <= (wr_ptr[idx] == PTR_TOP) ? '0 : wr_ptr[idx] + PTR_W'(1);
            fill[idx]   <= fill[idx] + FILL_W'(1);
          end
        end
        K_READ: begin
          if (rd_ok) begin
            rd_ptr[idx] <= (rd_ptr[idx] == PTR_TOP) ? '0 : rd_ptr[idx] + PTR_W'(1);
            fill[idx]   <= fill[idx] - FILL_W'(1);
          end
        end
        K_DUP_W: begin
          if (id_ok && (wrefs[idx] < REF_TOP)) begin
            wrefs[idx] <= wrefs[idx] + REF_W'(1);
          end
        end
        K_DUP_R: begin
          if (id_ok && (rrefs[idx] < REF_TOP)) begin
            rrefs[idx] <= rrefs[idx] + REF_W'(1);
          end
        end
        K_CLOSE_W: begin
          if (id_ok) begin
            wrefs[idx] <= w_dec;
            if ((w_dec == '0) && (rrefs[idx] == '0)) begin
              in_use[idx] <= 1'b0;
              fill[idx]   <= '0;
            end
          end
        end
        K_CLOSE_R: begin
          if (id_ok) begin
            rrefs[idx] <= r_dec;
            if ((r_dec == '0) && (wrefs[idx] == '0)) begin
              in_use[idx] <= 1'b0;
              fill[idx]   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // byte store
  ppbf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (pop && wr_ok),
    .waddr (waddr),
    .wdata (q_cmd.data),
    .re    (pop && rd_ok),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_READ) begin
      out_valid <= 1'b1;
    end else if (pop && !rd_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      res_status  <= ST_OK;
      new_pipe    <= '0;
      rd_byte     <= ram_rdata;
      moved_count <= pend_moved;
    end else if (pop && !rd_ok) begin
      res_status  <= st;
      new_pipe    <= grant;
      rd_byte     <= '0;
      moved_count <= moved;
    end
    if (pop && rd_ok) begin
      pend_moved <= moved;
    end
  end

  assign status = res_status;

  `ASSERT_ALWAYS(a_read_slot_free, clk, rst, (state != BK_READ) || !out_valid)
  `ASSERT_ALWAYS(a_free_pipe_clear, clk, rst, in_use[idx] || idx_idle)
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill[idx] <= FULL)

endmodule
